// ===== sv/gvm_pkg.sv =====
// shared types and constants for the granular voice mixer
// no dependencies; imported by gvm_ctrl, gvm_dp and granular_voice_mixer
`default_nettype none
package gvm_pkg;

	// default sizes handed to the top level parameters
	localparam int BUF_DEPTH_DEF  = 65536;
	localparam int MAX_VOICES_DEF = 10;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int RATE_W   = 20;
	localparam int MIX_W    = 20;
	localparam int ACC_W    = 22;
	localparam int CFG_W    = 32;
	localparam int FIU_W    = 17;

	// reset values
	localparam logic [31:0] PERIOD_RST = 32'd314572800;
	localparam logic [31:0] STEP_RST   = 32'd8948;
	localparam logic [16:0] FRAMES_RST = 17'd65536;
	localparam logic [31:0] ONE_Q16    = 32'h0001_0000;

	// item kinds
	typedef enum logic [1:0] {
		OP_MEM  = 2'd0,
		OP_RATE = 2'd1,
		OP_TICK = 2'd2
	} gvm_op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_PERIOD = 2'd0,
		CFG_STEP   = 2'd1,
		CFG_FRAMES = 2'd2
	} gvm_cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_RAMP,
		S_LOAD,
		S_ADV,
		S_IDX,
		S_RDA,
		S_RDB,
		S_MULA,
		S_MULB,
		S_ACC,
		S_FIN
	} gvm_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch;
		logic mem_wr;
		logic rate_wr;
		logic ramp;
		logic load;
		logic adv;
		logic idx;
		logic rd_a;
		logic rd_b;
		logic mul_a;
		logic mul_b;
		logic acc;
		logic finish;
	} gvm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] op;
		logic       last;
		logic       out_busy;
	} gvm_sts_t;

endpackage
`default_nettype wire

// ===== sv/gvm_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module gvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/gvm_ctrl.sv =====
// sequencing state machine for the granular voice mixer
// depends on gvm_pkg
`default_nettype none
module gvm_ctrl import gvm_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	input  wire gvm_sts_t sts,
	output gvm_cmd_t      cmd
);

	gvm_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_DEC;
			S_DEC: begin
				if (sts.op == OP_TICK) state_d = S_RAMP;
				else state_d = S_IDLE;
			end
			S_RAMP: state_d = S_LOAD;
			S_LOAD: state_d = S_ADV;
			S_ADV:  state_d = S_IDX;
			S_IDX:  state_d = S_RDA;
			S_RDA:  state_d = S_RDB;
			S_RDB:  state_d = S_MULA;
			S_MULA: state_d = S_MULB;
			S_MULB: state_d = S_ACC;
			S_ACC: begin
				if (sts.last) state_d = S_FIN;
				else state_d = S_ADV;
			end
			S_FIN: if (!sts.out_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.latch = s_tvalid;
			end
			S_DEC: begin
				cmd.mem_wr  = (sts.op == OP_MEM);
				cmd.rate_wr = (sts.op == OP_RATE);
			end
			S_RAMP: cmd.ramp  = 1'b1;
			S_LOAD: cmd.load  = 1'b1;
			S_ADV:  cmd.adv   = 1'b1;
			S_IDX:  cmd.idx   = 1'b1;
			S_RDA:  cmd.rd_a  = 1'b1;
			S_RDB:  cmd.rd_b  = 1'b1;
			S_MULA: cmd.mul_a = 1'b1;
			S_MULB: cmd.mul_b = 1'b1;
			S_ACC:  cmd.acc   = 1'b1;
			S_FIN:  cmd.finish = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/gvm_dp.sv =====
// datapath: config registers, voice state, sample memory and mixing arithmetic
// depends on gvm_pkg and gvm_ram
`default_nettype none
module gvm_dp import gvm_pkg::*; #(
	parameter int BUF_DEPTH  = BUF_DEPTH_DEF,
	parameter int MAX_VOICES = MAX_VOICES_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire  [55:0]      s_tdata,
	input  wire  [1:0]       s_tuser,
	input  wire              cfg_we,
	input  wire  [1:0]       cfg_index,
	input  wire  [CFG_W-1:0] cfg_wdata,
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [23:0]      m_tdata,
	output logic             m_tuser,
	input  wire gvm_cmd_t    cmd,
	output gvm_sts_t         sts
);

	localparam int AW  = $clog2(BUF_DEPTH);
	localparam int FW  = $clog2(BUF_DEPTH + 1);
	localparam int PW  = FW + 17;
	localparam int PSW = ((PW > RATE_W) ? PW : RATE_W) + 2;
	localparam int VW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int PRW = 32 + FW;

	// latched item
	logic [1:0]                 op_q;
	logic [15:0]                addr_q;
	logic [SAMPLE_W-1:0]        sval_q;
	logic [3:0]                 voice_q;
	logic signed [RATE_W-1:0]   rate_in_q;

	// config
	logic [31:0]      period_q, step_q;
	logic [FIU_W-1:0] fiu_q;

	// tick state
	logic [31:0]     ramp_q, grain_q;
	logic [VW-1:0]   cur_q, idx_q;
	logic            trig_q;
	logic [FW-1:0]   frames_q;
	logic [PRW-1:0]  prod_q;
	logic signed [PW-1:0]     ptr_q  [MAX_VOICES];
	logic signed [RATE_W-1:0] rate_q [MAX_VOICES];

	// per voice work registers
	logic signed [PW-1:0]       p_q;
	logic [AW-1:0]              frame_q, next_q;
	logic [15:0]                frac_q;
	logic                       zero_q;
	logic signed [SAMPLE_W-1:0] a_q, b_q;
	logic signed [33:0]         pa_q, pb_q;
	logic signed [ACC_W-1:0]    acc_q;

	// output register
	logic                    out_valid_q, out_trig_q;
	logic [MIX_W-1:0]        out_data_q;

	logic [SAMPLE_W-1:0]     rdata;

	// effective frame count
	logic [31:0] fiu32, eff32;
	always_comb begin
		fiu32 = 32'(fiu_q);
		if (fiu32 < 32'd2) eff32 = 32'd2;
		else if (fiu32 > 32'(BUF_DEPTH)) eff32 = 32'(BUF_DEPTH);
		else eff32 = fiu32;
	end

	// trigger ramp
	logic        trig_d;
	logic [31:0] ramp_sub, ramp_d;
	always_comb begin
		trig_d = (ramp_q >= period_q);
		ramp_sub = trig_d ? (ramp_q - period_q) : ramp_q;
		if (ramp_sub > (32'hFFFF_FFFF - ONE_Q16)) ramp_d = 32'hFFFF_FFFF;
		else ramp_d = ramp_sub + ONE_Q16;
	end

	// pointer advance with clamp
	logic signed [PW-1:0]  full_s;
	logic signed [PSW-1:0] psum, pfull;
	logic signed [PW-1:0]  pnew;
	always_comb begin
		full_s = PW'({frames_q, 16'b0});
		pfull  = PSW'(full_s);
		psum   = PSW'(ptr_q[idx_q]) + PSW'(rate_q[idx_q]);
		if (psum > pfull) pnew = full_s;
		else if (psum < -pfull) pnew = -full_s;
		else pnew = PW'(psum);
	end

	// frame index, next index and fraction
	logic signed [PW-1:0] r_s;
	logic [FW+15:0]       r_u;
	logic [FW-1:0]        fr_f;
	logic [FW:0]          nx_f;
	always_comb begin
		r_s  = (p_q <= 0) ? (full_s + p_q) : p_q;
		r_u  = r_s[FW+15:0];
		fr_f = r_u[FW+15:16];
		if (fr_f >= frames_q) fr_f = '0;
		nx_f = {1'b0, fr_f} + 1'b1;
		if (nx_f >= {1'b0, frames_q}) nx_f = '0;
	end

	// interpolation weights and rounding
	logic signed [17:0] wa, wb;
	logic signed [34:0] vsum, vrnd;
	logic signed [ACC_W-1:0] vval;
	always_comb begin
		wb   = 18'({2'b0, frac_q});
		wa   = 18'sh10000 - wb;
		vsum = 35'(pa_q) + 35'(pb_q);
		vrnd = (vsum + 35'sd32768) >>> 16;
		vval = zero_q ? '0 : ACC_W'(vrnd);
	end

	// mix saturation
	logic [MIX_W-1:0] mix_sat;
	always_comb begin
		if (acc_q > ACC_W'(524287)) mix_sat = 20'h7FFFF;
		else if (acc_q < -ACC_W'(524288)) mix_sat = 20'h80000;
		else mix_sat = acc_q[MIX_W-1:0];
	end

	// sample memory
	logic          mem_ok;
	logic [31:0]   addr32;
	assign addr32 = 32'(addr_q);
	assign mem_ok = (addr32 < 32'(BUF_DEPTH));

	gvm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(BUF_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.mem_wr && mem_ok),
		.waddr(addr32[AW-1:0]),
		.wdata(sval_q),
		.re   (cmd.rd_a || cmd.rd_b),
		.raddr(cmd.rd_a ? frame_q : next_q),
		.rdata(rdata)
	);

	// item latch and per voice work registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= s_tuser;
			addr_q    <= s_tdata[15:0];
			sval_q    <= s_tdata[31:16];
			voice_q   <= s_tdata[35:32];
			rate_in_q <= s_tdata[55:36];
		end
		if (cmd.ramp) begin
			prod_q   <= PRW'(grain_q) * PRW'(eff32[FW-1:0]);
			frames_q <= eff32[FW-1:0];
		end
		if (cmd.adv) p_q <= pnew;
		if (cmd.idx) begin
			zero_q  <= (p_q >= full_s);
			frame_q <= fr_f[AW-1:0];
			next_q  <= nx_f[AW-1:0];
			frac_q  <= r_u[15:0];
		end
		if (cmd.rd_b) a_q <= rdata;
		if (cmd.mul_a) begin
			pa_q <= 34'(a_q) * 34'(wa);
			b_q  <= rdata;
		end
		if (cmd.mul_b) pb_q <= 34'(b_q) * 34'(wb);
		if (cmd.finish) begin
			out_data_q <= mix_sat;
			out_trig_q <= trig_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RST;
			step_q      <= STEP_RST;
			fiu_q       <= FRAMES_RST;
			ramp_q      <= '0;
			grain_q     <= '0;
			cur_q       <= '0;
			idx_q       <= '0;
			trig_q      <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_VOICES; i++) begin
				ptr_q[i]  <= '0;
				rate_q[i] <= (i == 0) ? RATE_W'(ONE_Q16) : '0;
			end
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_PERIOD: period_q <= cfg_wdata;
					CFG_STEP:   step_q   <= cfg_wdata;
					CFG_FRAMES: fiu_q    <= cfg_wdata[FIU_W-1:0];
					default: ;
				endcase
			end
			// voice rate write
			if (cmd.rate_wr && (32'(voice_q) < 32'(MAX_VOICES))) begin
				rate_q[voice_q[VW-1:0]] <= rate_in_q;
			end
			// trigger decision
			if (cmd.ramp) begin
				ramp_q <= ramp_d;
				trig_q <= trig_d;
				if (trig_d) begin
					cur_q <= (cur_q == VW'(MAX_VOICES - 1)) ? '0 : cur_q + 1'b1;
				end
			end
			// grain restart
			if (cmd.load) begin
				if (trig_q) ptr_q[cur_q] <= PW'(prod_q[FW+31:16]);
				idx_q <= '0;
				acc_q <= '0;
			end
			if (cmd.adv) ptr_q[idx_q] <= pnew;
			if (cmd.acc) begin
				acc_q <= acc_q + vval;
				if (idx_q != VW'(MAX_VOICES - 1)) idx_q <= idx_q + 1'b1;
			end
			// result register
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
				grain_q     <= grain_q + step_q;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, out_data_q};
	assign m_tuser  = out_trig_q;

	assign sts.op       = op_q;
	assign sts.last     = (idx_q == VW'(MAX_VOICES - 1));
	assign sts.out_busy = out_valid_q && !m_tready;

endmodule
`default_nettype wire

// ===== sv/granular_voice_mixer.sv =====
// granular grain player with a voice mixer; top level
// memory and rate items: each accepted in idle, then a decode state before the next is taken
// tick: accept, decode, ramp, load, then per voice pointer update, index, two sample reads,
// two products and accumulate, then finish; the next item is taken once back in idle
// a result waiting in the output register stalls the finish; depends on gvm_pkg, gvm_ctrl, gvm_dp, gvm_ram
// async reset clears voice pointers, ramp and grain position and loads the config defaults
`default_nettype none
module granular_voice_mixer import gvm_pkg::*; #(
	parameter int BUF_DEPTH  = BUF_DEPTH_DEF,
	parameter int MAX_VOICES = MAX_VOICES_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  wire  [55:0]      s_tdata,   // address, sample_value, voice, rate
	input  wire  [1:0]       s_tuser,   // op
	output logic             m_tvalid,
	input  wire              m_tready,
	output logic [23:0]      m_tdata,   // mixed_sample, zero fill
	output logic             m_tuser,   // trigger
	input  wire              cfg_we,
	input  wire  [1:0]       cfg_index,
	input  wire  [CFG_W-1:0] cfg_wdata
);

	gvm_cmd_t cmd;
	gvm_sts_t sts;

	gvm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	gvm_dp #(
		.BUF_DEPTH (BUF_DEPTH),
		.MAX_VOICES(MAX_VOICES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
`default_nettype wire

// ===== tb/sv/granular_voice_mixer_tb.sv =====
// self-checking testbench for granular_voice_mixer: streams memory, rate and tick items
// with random gaps and output stalls, predicts every mixed sample, compares in order
// depends on gvm_pkg and the granular_voice_mixer RTL
`timescale 1ns / 1ps
module granular_voice_mixer_tb;
	import gvm_pkg::*;

	localparam int NVOICE      = 10;
	localparam int MEM_WORDS   = 65536;
	localparam int FILL_WORDS  = 256;
	localparam int SETTLE      = 120;
	localparam int STALL_MAX   = 20000;
	localparam int HOLD_CYCLES = 1500;

	typedef struct packed {
		logic [19:0] mix;
		logic        trig;
	} mix_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	granular_voice_mixer DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// predicted voice state and registers
	logic signed [15:0] pm_mem [MEM_WORDS];
	longint             pm_ptr [NVOICE];
	longint             pm_rate [NVOICE];
	logic [31:0]        pm_ramp, pm_gpos, pm_period, pm_step;
	logic [16:0]        pm_frames;
	int                 pm_voice;

	mix_result_t pending_mix[$];
	int          mismatches = 0;
	bit          idle_on = 1'b1;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_cnt = 0;
	int          quiet_cycles = 0;

	// interpolated sample of one voice
	function automatic longint voice_sample(longint r, longint frames);
		longint full, frame, nxt, frac, a, b, v;
		full = frames <<< 16;
		if (r >= full) return 0;
		if (r <= 0) r = full + r;
		frame = r >>> 16;
		frac = r & 64'hFFFF;
		if (frame >= frames) frame = 0;
		nxt = frame + 1;
		if (nxt >= frames) nxt = 0;
		a = pm_mem[frame];
		b = pm_mem[nxt];
		v = a * (65536 - frac) + b * frac;
		return (v + 32768) >>> 16;
	endfunction

	// one tick of the grain player
	function automatic mix_result_t tick_mix();
		mix_result_t res;
		longint frames, full, p, sum;
		logic [63:0] prod;
		frames = pm_frames < 2 ? 2 : (pm_frames > MEM_WORDS ? MEM_WORDS : pm_frames);
		full = frames <<< 16;
		sum = 0;
		res.trig = 1'b0;
		if (pm_ramp >= pm_period) begin
			pm_ramp = pm_ramp - pm_period;
			pm_voice = (pm_voice + 1) % NVOICE;
			res.trig = 1'b1;
			prod = 64'(pm_gpos) * 64'(frames);
			pm_ptr[pm_voice] = longint'(prod >> 16);
		end
		if (pm_ramp > 32'hFFFF_FFFF - ONE_Q16) pm_ramp = 32'hFFFF_FFFF;
		else pm_ramp = pm_ramp + ONE_Q16;
		for (int v = 0; v < NVOICE; v++) begin
			p = pm_ptr[v] + pm_rate[v];
			if (p > full) p = full;
			if (p < -full) p = -full;
			pm_ptr[v] = p;
			sum += voice_sample(p, frames);
		end
		pm_gpos = pm_gpos + pm_step;
		if (sum > 524287) sum = 524287;
		if (sum < -524288) sum = -524288;
		res.mix = sum[19:0];
		return res;
	endfunction

	// predict the effect of one accepted item
	function automatic void predict_item(logic [1:0] op, logic [55:0] d);
		case (op)
			OP_MEM: pm_mem[d[15:0]] = d[31:16];
			OP_RATE: if (d[35:32] < NVOICE) pm_rate[d[35:32]] = longint'($signed(d[55:36]));
			OP_TICK: pending_mix.push_back(tick_mix());
			default: ;
		endcase
	endfunction

	// lower tvalid after the last accepted item
	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// offer one item, optionally after a random gap, and wait until it is taken
	task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [15:0] smp,
			logic [3:0] vc, logic [19:0] rate);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(99) < 34) gap = $urandom_range(6, 1);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {rate, vc, smp, addr};
		@(posedge clk iff s_tready);
		predict_item(op, {rate, vc, smp, addr});
	endtask

	task automatic wait_drained();
		while (pending_mix.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write while the block is idle
	task automatic write_reg(gvm_cfg_t idx, logic [31:0] val);
		stop_sending();
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PERIOD: pm_period = val;
			CFG_STEP: pm_step = val;
			CFG_FRAMES: pm_frames = val[16:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [31:0] period, logic [31:0] step, logic [16:0] frames);
		write_reg(CFG_PERIOD, period);
		write_reg(CFG_STEP, step);
		write_reg(CFG_FRAMES, {15'd0, frames});
	endtask

	function automatic logic [19:0] pick_rate();
		int r;
		if ($urandom_range(99) < 70) begin
			r = int'($urandom_range(6 * 65536)) - 3 * 65536;
			return r[19:0];
		end
		return 20'($urandom());
	endfunction

	task automatic send_tick();
		send_item(OP_TICK, 16'($urandom()), 16'($urandom()), 4'($urandom()),
			20'($urandom()));
	endtask

	// one random item: mostly ticks, some writes, a little noise
	task automatic send_random();
		int k;
		k = $urandom_range(99);
		if (k < 55) send_tick();
		else if (k < 75) send_item(OP_MEM, 16'($urandom()), 16'($urandom()),
				4'($urandom()), 20'($urandom()));
		else if (k < 93) send_item(OP_RATE, 16'($urandom()), 16'($urandom()),
				4'($urandom_range(NVOICE - 1)), pick_rate());
		else if (k < 96) send_item(OP_RATE, 16'($urandom()), 16'($urandom()),
				4'($urandom_range(15, NVOICE)), 20'($urandom()));
		else send_item(2'd3, 16'($urandom()), 16'($urandom()), 4'($urandom()),
				20'($urandom()));
	endtask

	// the frame count is kept within the filled words, so every read hits a written word
	task automatic test_fill_memory();
		for (int a = 0; a < FILL_WORDS; a++)
			send_item(OP_MEM, a[15:0], 16'($urandom()), 4'($urandom()), 20'($urandom()));
		write_reg(CFG_FRAMES, 32'(FILL_WORDS));
	endtask

	// field extremes and the ignored cases
	task automatic test_directed();
		send_tick();
		send_item(OP_MEM, 16'd0, 16'h8000, 4'd0, 20'd0);
		send_item(OP_MEM, 16'hFFFF, 16'h7FFF, 4'hF, 20'hFFFFF);
		send_item(OP_MEM, 16'd1, 16'h7FFF, 4'd0, 20'd0);
		send_tick();
		send_item(OP_RATE, 16'd0, 16'd0, 4'd1, 20'h7FFFF);
		send_item(OP_RATE, 16'd0, 16'd0, 4'd9, 20'h80000);
		send_item(OP_RATE, 16'hFFFF, 16'hFFFF, 4'd15, 20'h12345);
		send_item(OP_RATE, 16'd0, 16'd0, 4'd10, 20'h7FFFF);
		send_item(2'd3, 16'hFFFF, 16'hFFFF, 4'hF, 20'hFFFFF);
		repeat (6) send_tick();
		// all voices at full speed give a large mix
		for (int v = 0; v < NVOICE; v++)
			send_item(OP_RATE, 16'd0, 16'd0, v[3:0], 20'h10000);
		repeat (4) send_tick();
	endtask

	task automatic test_random_phase(int n);
		repeat (n) send_random();
	endtask

	// receiver holds off while ticks keep coming, then the sender pauses to drain
	task automatic test_backpressure();
		stop_sending();
		hold_req++;
		repeat (30) send_tick();
		stop_sending();
		wait_drained();
	endtask

	task automatic test_settings();
		set_regs(32'd0, 32'd0, 17'd2);
		test_random_phase(200);
		set_regs(32'd65535, 32'hFFFF_FFFF, 17'd0);
		test_random_phase(200);
		set_regs(32'hFFFF_FFFF, $urandom(), 17'(FILL_WORDS - 1));
		test_random_phase(200);
		set_regs(32'd65536 * $urandom_range(20, 1), $urandom(),
			17'($urandom_range(FILL_WORDS, 2)));
		idle_on = 1'b0;
		test_random_phase(300);
		idle_on = 1'b1;
		set_regs(32'd65536, $urandom(), 17'(FILL_WORDS));
		test_random_phase(300);
		set_regs(32'd65536 * $urandom_range(8, 1), $urandom(),
			17'($urandom_range(FILL_WORDS, 2)));
		test_random_phase(300);
	endtask

	// output side: random stalls and the long hold-off
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_cnt <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (idle_on) begin
			m_tready <= ($urandom_range(99) >= 34);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin
		mix_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_mix.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result mix=%h trig=%b", m_tdata, m_tuser);
			end else begin
				want = pending_mix.pop_front();
				if (m_tdata !== {4'd0, want.mix} || m_tuser !== want.trig) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected mix=%h trig=%b, got mix=%h trig=%b",
							want.mix, want.trig, m_tdata, m_tuser);
				end
			end
		end
	end

	// watchdog on cycles with no accepted item on either side and no config write
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_MAX) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		for (int v = 0; v < NVOICE; v++) begin
			pm_ptr[v] = 0;
			pm_rate[v] = 0;
		end
		pm_rate[0] = 65536;
		pm_ramp = '0;
		pm_gpos = '0;
		pm_voice = 0;
		pm_period = PERIOD_RST;
		pm_step = STEP_RST;
		pm_frames = FRAMES_RST;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_memory();
		test_directed();
		test_backpressure();
		test_random_phase(100);
		test_settings();
		stop_sending();
		wait_drained();
		if (mismatches == 0 && pending_mix.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/gvm_pkg.sv
sv/gvm_ram.sv
sv/gvm_ctrl.sv
sv/gvm_dp.sv
sv/granular_voice_mixer.sv
tb/sv/granular_voice_mixer_tb.sv
